// File: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and row-table structs for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;

	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int HI_W   = $clog2(SCREEN_COLS + 1);
	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic REG_ATTR  = 1'b0;
	localparam logic REG_BLANK = 1'b1;

	localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [7:0]  ATTR_RESET   = 8'h07;
	localparam logic [15:0] BLANK_RESET  = 16'h0720;

	typedef logic [COL_W-1:0] col_t;
	typedef logic [HI_W-1:0]  hi_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [15:0]      cell_t;

	typedef struct packed {
		logic  clear;
		logic  scroll;
		logic  put_wr;
		col_t  cur_col;
		row_t  cur_row;
		row_t  rd_row;
		col_t  rd_col;
		cell_t blank;
	} rt_req_t;

	typedef struct packed {
		row_t  cur_phys;
		row_t  rd_phys;
		logic  rd_written;
		cell_t rd_blank;
	} rt_look_t;

endpackage

// File: sv/tcw_cmd_if.sv
// ----------------------------------------------------------------------------
// tcw_cmd_if
// Command channel: one console command per item.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] char_code;
	logic [4:0] read_row;
	logic [6:0] read_col;

	modport source (output valid, output cmd, output char_code, output read_row,
		output read_col, input ready);
	modport sink (input valid, input cmd, input char_code, input read_row,
		input read_col, output ready);
endinterface

// File: sv/tcw_res_if.sv
// ----------------------------------------------------------------------------
// tcw_res_if
// Result channel: cursor position, read cell and scroll flag per item.
// ----------------------------------------------------------------------------
interface tcw_res_if;
	logic        valid;
	logic        ready;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [15:0] cell_data;
	logic        scrolled;

	modport source (output valid, output cursor_col, output cursor_row,
		output cell_data, output scrolled, input ready);
	modport sink (input valid, input cursor_col, input cursor_row,
		input cell_data, input scrolled, output ready);
endinterface

// File: sv/tcw_cfg_if.sv
// ----------------------------------------------------------------------------
// tcw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: screen RAM, row table, cursor and result pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, clear and scroll included, unless rsp stalls.
// RAM read and stage one load on accept; the result registers load on advance.
// Clear and scroll retag rows in the row table, so the screen RAM is not swept.
// Reset: cursor, registers and row table restore at once; no clearing pass.
// ----------------------------------------------------------------------------
module text_console_writer_core (
	input  logic     clk,
	input  logic     arst_n,
	tcw_cmd_if.sink  req,
	tcw_res_if.source rsp,
	tcw_cfg_if.sink  cfg
);
	import tcw_pkg::*;

	function automatic logic [ADDR_W-1:0] cell_addr(input row_t r, input col_t c);
		return ADDR_W'(int'(r) * SCREEN_COLS + int'(c));
	endfunction

	logic [7:0] attr_q;
	cell_t      blank_q;
	col_t       cur_col_q;
	row_t       cur_row_q;

	logic  v_s1;
	col_t  col_s1;
	row_t  row_s1;
	logic  scr_s1;
	logic  rd_s1;
	logic  wr_s1;
	cell_t blank_s1;

	logic        out_v_q;
	logic [6:0]  out_col_q;
	logic [4:0]  out_row_q;
	cell_t       out_cell_q;
	logic        out_scr_q;

	logic     accept;
	logic     advance;
	logic     is_put;
	logic     is_clear;
	logic     is_read;
	logic     rd_ok;
	row_t     rd_row_i;
	col_t     rd_col_i;
	logic     newline;
	hi_t      col_inc;
	logic     put_wr;
	logic     line_adv;
	logic     last_row;
	logic     scroll;
	col_t     nxt_col;
	row_t     nxt_row;
	rt_req_t  rt_req;
	rt_look_t rt_look;
	cell_t    ram_q;
	cell_t    cell_s1;

	assign accept    = req.valid && req.ready;
	assign advance   = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || !out_v_q || rsp.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		is_put   = (req.cmd == CMD_PUT);
		is_clear = (req.cmd == CMD_CLEAR);
		is_read  = (req.cmd == CMD_READ);
		rd_ok    = (int'(req.read_row) < SCREEN_ROWS) && (int'(req.read_col) < SCREEN_COLS);
		rd_row_i = rd_ok ? ROW_W'(req.read_row) : '0;
		rd_col_i = rd_ok ? COL_W'(req.read_col) : '0;
		newline  = (req.char_code == NEWLINE_CODE);
		col_inc  = HI_W'(cur_col_q) + HI_W'(1);
		put_wr   = is_put && !newline;
		line_adv = is_put && (newline || (col_inc == HI_W'(SCREEN_COLS)));
		last_row = (cur_row_q == ROW_W'(SCREEN_ROWS - 1));
		scroll   = line_adv && last_row;
		if (!is_put) begin
			nxt_col = cur_col_q;
		end else if (line_adv) begin
			nxt_col = '0;
		end else begin
			nxt_col = COL_W'(col_inc);
		end
		nxt_row = (line_adv && !last_row) ? cur_row_q + ROW_W'(1) : cur_row_q;

		rt_req.clear   = accept && is_clear;
		rt_req.scroll  = accept && scroll;
		rt_req.put_wr  = accept && put_wr;
		rt_req.cur_col = cur_col_q;
		rt_req.cur_row = cur_row_q;
		rt_req.rd_row  = rd_row_i;
		rt_req.rd_col  = rd_col_i;
		rt_req.blank   = blank_q;

		if (!rd_s1) begin
			cell_s1 = '0;
		end else if (wr_s1) begin
			cell_s1 = ram_q;
		end else begin
			cell_s1 = blank_s1;
		end
	end

	tcw_rowtab u_rowtab (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rt_req),
		.look   (rt_look)
	);

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (accept && put_wr),
		.waddr (cell_addr(rt_look.cur_phys, cur_col_q)),
		.wdata ({attr_q, req.char_code}),
		.re    (accept && is_read && rd_ok),
		.raddr (cell_addr(rt_look.rd_phys, rd_col_i)),
		.rdata (ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q    <= ATTR_RESET;
			blank_q   <= BLANK_RESET;
			cur_col_q <= '0;
			cur_row_q <= '0;
			v_s1      <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ATTR: attr_q <= cfg.data[7:0];
					REG_BLANK: blank_q <= cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				cur_col_q <= nxt_col;
				cur_row_q <= nxt_row;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= nxt_col;
			row_s1   <= nxt_row;
			scr_s1   <= scroll;
			rd_s1    <= is_read && rd_ok;
			wr_s1    <= rt_look.rd_written;
			blank_s1 <= rt_look.rd_blank;
		end
		if (advance) begin
			out_col_q  <= 7'(col_s1);
			out_row_q  <= 5'(row_s1);
			out_cell_q <= cell_s1;
			out_scr_q  <= scr_s1;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.cursor_col = out_col_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cell_data  = out_cell_q;
	assign rsp.scrolled   = out_scr_q;
endmodule

// File: sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: sv/tcw_rowtab.sv
// ----------------------------------------------------------------------------
// tcw_rowtab
// Row table: rotating row base, per-row blank value and written column span.
// ----------------------------------------------------------------------------
module tcw_rowtab (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::rt_req_t   req,
	output tcw_pkg::rt_look_t  look
);
	import tcw_pkg::*;

	localparam logic [ROW_W:0] ROWS_X = (ROW_W + 1)'(SCREEN_ROWS);

	row_t  base_q;
	col_t  lo_q    [SCREEN_ROWS];
	hi_t   hi_q    [SCREEN_ROWS];
	cell_t blank_q [SCREEN_ROWS];

	logic [ROW_W:0] cur_sum;
	logic [ROW_W:0] rd_sum;
	row_t           cur_phys;
	row_t           rd_phys;
	hi_t            rd_col_x;

	always_comb begin
		cur_sum  = {1'b0, base_q} + {1'b0, req.cur_row};
		rd_sum   = {1'b0, base_q} + {1'b0, req.rd_row};
		cur_phys = (cur_sum >= ROWS_X) ? ROW_W'(cur_sum - ROWS_X) : ROW_W'(cur_sum);
		rd_phys  = (rd_sum >= ROWS_X) ? ROW_W'(rd_sum - ROWS_X) : ROW_W'(rd_sum);
		rd_col_x = HI_W'(req.rd_col);

		look.cur_phys   = cur_phys;
		look.rd_phys    = rd_phys;
		look.rd_written = (rd_col_x >= HI_W'(lo_q[rd_phys])) && (rd_col_x < hi_q[rd_phys]);
		look.rd_blank   = blank_q[rd_phys];
	end

	// cells of a row written since its last blanking form one span [lo, hi)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			for (int r = 0; r < SCREEN_ROWS; r++) begin
				lo_q[r]    <= '0;
				hi_q[r]    <= '0;
				blank_q[r] <= BLANK_RESET;
			end
		end else if (req.clear) begin
			for (int r = 0; r < SCREEN_ROWS; r++) begin
				blank_q[r] <= req.blank;
				if (ROW_W'(r) == cur_phys) begin
					lo_q[r] <= req.cur_col;
					hi_q[r] <= HI_W'(req.cur_col);
				end else begin
					lo_q[r] <= '0;
					hi_q[r] <= '0;
				end
			end
		end else begin
			if (req.put_wr) begin
				hi_q[cur_phys] <= HI_W'(req.cur_col) + HI_W'(1);
			end
			if (req.scroll) begin
				lo_q[base_q]    <= '0;
				hi_q[base_q]    <= '0;
				blank_q[base_q] <= req.blank;
				base_q          <= (base_q == ROW_W'(SCREEN_ROWS - 1)) ? '0
					: base_q + ROW_W'(1);
			end
		end
	end
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_writer_core. Commands go in through the
// command channel in random bursts; a local screen and cursor model predicts
// every result, and the result channel, stalled on its own pattern, is compared
// field by field in order. Attribute and blank registers are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [6:0]  col;
		logic [4:0]  row;
		logic [15:0] cell_val;
		logic        scrolled;
	} console_result_t;

	typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_BURSTY} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	tcw_cmd_if req_ch();
	tcw_res_if res_ch();
	tcw_cfg_if cfg_ch();

	text_console_writer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cell_t       screen_copy [CELLS];
	int unsigned pred_col;
	int unsigned pred_row;
	logic [7:0]  attr_reg;
	cell_t       blank_reg;

	console_result_t pending_results [$];
	int              mismatch_count;
	int              burst_left;

	sink_mode_t  sink_mode;
	int          sink_mode_left;
	int          sink_hold;
	int unsigned sink_cyc;

	function automatic void reset_screen_model();
		attr_reg  = ATTR_RESET;
		blank_reg = BLANK_RESET;
		pred_col  = 0;
		pred_row  = 0;
		foreach (screen_copy[i])
			screen_copy[i] = BLANK_RESET;
	endfunction

	function automatic console_result_t apply_console_cmd(logic [1:0] op, logic [7:0] ch,
		logic [4:0] rr, logic [6:0] rc);
		console_result_t r;
		r = '0;
		case (op)
			CMD_PUT: begin
				if (ch == NEWLINE_CODE) begin
					pred_col = 0;
					pred_row++;
				end else begin
					screen_copy[pred_row * SCREEN_COLS + pred_col] = {attr_reg, ch};
					pred_col++;
				end
				if (pred_col >= SCREEN_COLS) begin
					pred_col = 0;
					pred_row++;
				end
				if (pred_row >= SCREEN_ROWS) begin
					for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++)
						screen_copy[i] = screen_copy[i + SCREEN_COLS];
					for (int i = SCREEN_COLS * (SCREEN_ROWS - 1); i < CELLS; i++)
						screen_copy[i] = blank_reg;
					pred_row   = SCREEN_ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			CMD_CLEAR: begin
				foreach (screen_copy[i])
					screen_copy[i] = blank_reg;
			end
			CMD_READ: begin
				if (rr < SCREEN_ROWS && rc < SCREEN_COLS)
					r.cell_val = screen_copy[rr * SCREEN_COLS + rc];
			end
			default: ;
		endcase
		r.col = pred_col[6:0];
		r.row = pred_row[4:0];
		return r;
	endfunction

	// one command item; valid stays high into the next item unless a gap is due
	task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.char_code <= ch;
		req_ch.read_row  <= rr;
		req_ch.read_col  <= rc;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(apply_console_cmd(op, ch, rr, rc));
	endtask

	task automatic put_char(logic [7:0] ch);
		send_cmd(CMD_PUT, ch, 5'($urandom), 7'($urandom));
	endtask

	task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
		send_cmd(CMD_READ, 8'($urandom), rr, rc);
	endtask

	task automatic settle_idle();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		settle_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_ATTR)
			attr_reg = value[7:0];
		else
			blank_reg = value;
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] ch;
		do ch = 8'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
		return ch;
	endfunction

	task automatic send_random_item();
		int sel;
		logic [4:0] rr;
		sel = $urandom_range(0, 99);
		if (sel < 62) begin
			put_char(8'($urandom_range(0, 255)));
		end else if (sel < 70) begin
			put_char(NEWLINE_CODE);
		end else if (sel < 72) begin
			send_cmd(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
		end else if (sel < 94) begin
			if ($urandom_range(0, 1) == 0)
				rr = 5'(pred_row);
			else
				rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
			read_cell(rr, 7'($urandom_range(0, SCREEN_COLS - 1)));
		end else if (sel < 97) begin
			read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
		end else begin
			send_cmd(CMD_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
		end
	endtask

	task automatic test_reset_contents();
		read_cell(5'd0, 7'd0);
		read_cell(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
		read_cell(5'd31, 7'd127);
		read_cell(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS));
		read_cell(5'(SCREEN_ROWS), 7'd0);
		send_cmd(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
		send_cmd(CMD_UNUSED, 8'h00, 5'd0, 7'd0);
	endtask

	task automatic test_char_extremes();
		put_char(8'h00);
		put_char(8'hFF);
		put_char(8'h80);
		put_char(8'h7F);
		for (int c = 0; c < 4; c++)
			read_cell(5'd0, 7'(c));
		put_char(NEWLINE_CODE);
		put_char(8'h41);
		read_cell(5'd1, 7'd0);
		send_cmd(CMD_CLEAR, 8'h0A, 5'd31, 7'd127);
		read_cell(5'd0, 7'd1);
		read_cell(5'd1, 7'd0);
		send_cmd(CMD_READ, NEWLINE_CODE, 5'd0, 7'd0);
		settle_idle();
	endtask

	task automatic test_line_wrap();
		for (int c = 0; c < SCREEN_COLS + 3; c++)
			put_char(text_byte());
		read_cell(5'(pred_row - 1), 7'(SCREEN_COLS - 1));
		read_cell(5'(pred_row - 1), 7'd0);
		read_cell(5'(pred_row), 7'd0);
		settle_idle();
	endtask

	task automatic test_scroll();
		while (pred_row != SCREEN_ROWS - 1) begin
			put_char(text_byte());
			put_char(NEWLINE_CODE);
		end
		for (int c = 0; c < SCREEN_COLS; c++)
			put_char(text_byte());
		read_cell(5'(SCREEN_ROWS - 2), 7'd0);
		read_cell(5'(SCREEN_ROWS - 1), 7'd0);
		for (int k = 0; k < 4; k++) begin
			put_char(text_byte());
			put_char(NEWLINE_CODE);
		end
		read_cell(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
		read_cell(5'(SCREEN_ROWS - 2), 7'd0);
		read_cell(5'd0, 7'd0);
		settle_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_ATTR, 16'h0000);
		write_reg(REG_BLANK, 16'h0000);
		put_char(8'hFF);
		put_char(NEWLINE_CODE);
		read_cell(5'(pred_row - 1), 7'd0);
		read_cell(5'(SCREEN_ROWS - 1), 7'd0);
		send_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
		read_cell(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
		write_reg(REG_ATTR, 16'h00FF);
		write_reg(REG_BLANK, 16'hFFFF);
		put_char(8'h00);
		read_cell(5'(pred_row), 7'(pred_col - 1));
		read_cell(5'd0, 7'd0);
		for (int k = 0; k < SCREEN_ROWS; k++)
			put_char(NEWLINE_CODE);
		read_cell(5'(SCREEN_ROWS - 1), 7'($urandom_range(0, SCREEN_COLS - 1)));
		read_cell(5'd0, 7'd0);
		send_cmd(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
		read_cell(5'd12, 7'd40);
		write_reg(REG_ATTR, 16'hFF07);
		write_reg(REG_BLANK, BLANK_RESET);
		settle_idle();
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_ATTR, 16'($urandom_range(0, 255)));
			write_reg(REG_BLANK, 16'($urandom_range(0, 65535)));
			for (int n = 0; n < 178; n++)
				send_random_item();
		end
		settle_idle();
	endtask

	// result checker and sink stall pattern
	always @(posedge clk) begin
		console_result_t got;
		console_result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got = {res_ch.cursor_col, res_ch.cursor_row, res_ch.cell_data, res_ch.scrolled};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item: col %0d row %0d cell %h scrolled %b",
						got.col, got.row, got.cell_val, got.scrolled);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: col/row/cell/scr expected %0d %0d %h %b, got %0d %0d %h %b",
							want.col, want.row, want.cell_val, want.scrolled,
							got.col, got.row, got.cell_val, got.scrolled);
				end
			end
		end
		sink_cyc++;
		if (sink_mode_left == 0) begin
			sink_mode      = sink_mode_t'($urandom_range(0, 3));
			sink_mode_left = $urandom_range(50, 400);
		end else begin
			sink_mode_left--;
		end
		case (sink_mode)
			SINK_OPEN:     res_ch.ready <= 1'b1;
			SINK_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
			SINK_PERIODIC: res_ch.ready <= ((sink_cyc % 7) < 4);
			default: begin
				if (sink_hold > 0) begin
					sink_hold--;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						sink_hold = $urandom_range(1, 15);
				end
			end
		endcase
	end

	initial begin
		#5ms;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		mismatch_count   = 0;
		burst_left       = 0;
		sink_mode        = SINK_OPEN;
		sink_mode_left   = 0;
		sink_hold        = 0;
		sink_cyc         = 0;
		arst_n           = 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= CMD_PUT;
		req_ch.char_code <= 8'h00;
		req_ch.read_row  <= 5'd0;
		req_ch.read_col  <= 7'd0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= REG_ATTR;
		cfg_ch.data      <= 16'h0000;
		reset_screen_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_char_extremes();
		test_line_wrap();
		test_scroll();
		test_register_extremes();
		test_random_traffic();

		settle_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// File: text_console_writer_core.f
sv/tcw_pkg.sv
sv/tcw_cmd_if.sv
sv/tcw_res_if.sv
sv/tcw_cfg_if.sv
sv/tcw_ram.sv
sv/tcw_rowtab.sv
sv/text_console_writer_core.sv
tb/testbench.sv
